// ===== rtl/pfs_pkg.sv =====
package pfs_pkg;

  localparam int TABLE_SIZE = 65536;
  localparam int VAL_W      = 16;
  localparam int ENT_W      = 8;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int POS_W      = ADDR_W + 1;
  localparam int DIV_W      = $clog2(VAL_W);

  // Largest sieving base whose square still lies inside the table.
  function automatic int sieve_top(input int limit);
    int r;
    r = 1;
    while (((r + 1) * (r + 1) < limit) && (r < 255)) begin
      r = r + 1;
    end
    return r;
  endfunction

  localparam logic [ENT_W-1:0] SIEVE_TOP = ENT_W'(sieve_top(TABLE_SIZE));

  typedef struct packed {
    logic clr_step;
    logic row_init;
    logic mark;
    logic next_base;
    logic load_n;
    logic rd;
    logic pick;
    logic div_step;
    logic emit;
    logic emit_none;
  } pfs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic row_last;
    logic base_last;
    logic val_ok;
    logic val_small;
    logic is_prime;
    logic div_last;
    logic q_one;
    logic out_free;
  } pfs_sts_t;

endpackage

// ===== rtl/pfs_ram.sv =====
module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/pfs_ctrl.sv =====
module pfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfs_pkg::pfs_sts_t sts,
  output pfs_pkg::pfs_cmd_t cmd
);

  import pfs_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_ROW   = 9'b000000010,
    S_MARK  = 9'b000000100,
    S_IDLE  = 9'b000001000,
    S_NONE  = 9'b000010000,
    S_READ  = 9'b000100000,
    S_PICK  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        cmd.row_init = 1'b1;
        state_nxt    = S_MARK;
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.row_last) begin
          if (sts.base_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_base = 1'b1;
            state_nxt     = S_ROW;
          end
        end
      end
      S_IDLE: begin
        // A value outside the table is taken and dropped without a result.
        if (in_valid && sts.val_ok) begin
          cmd.load_n = 1'b1;
          state_nxt  = sts.val_small ? S_NONE : S_READ;
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = sts.is_prime ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.q_one ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pfs_dpath.sv =====
module pfs_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pfs_pkg::pfs_cmd_t         cmd,
  output pfs_pkg::pfs_sts_t         sts,
  input  logic [pfs_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pfs_pkg::VAL_W-1:0] out_factor,
  output logic                      out_last,
  output logic                      out_none
);

  import pfs_pkg::*;

  logic [POS_W-1:0]  pos_r;
  logic [ENT_W-1:0]  base_r;
  logic [VAL_W-1:0]  n_r;
  logic [VAL_W-1:0]  f_r;
  logic [VAL_W-1:0]  q_r;
  logic [ENT_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dcnt_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_factor_r;
  logic              out_last_r;
  logic              out_none_r;

  logic [POS_W-1:0]  pos_adv;
  logic [VAL_W-1:0]  base_sq;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  logic [ENT_W:0]    rem_sh;
  logic [ENT_W:0]    divisor;
  logic              sub_ok;
  logic [ENT_W:0]    rem_sub;

  pfs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.rd),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Bases are swept from the top down and every multiple from the base's square up
  // is overwritten, so each entry ends up holding its smallest base, with no read needed.
  assign pos_adv   = pos_r + POS_W'(base_r);
  assign base_sq   = VAL_W'(base_r) * VAL_W'(base_r);
  assign ram_we    = cmd.clr_step | cmd.mark;
  assign ram_addr  = ram_we ? pos_r[ADDR_W-1:0] : n_r[ADDR_W-1:0];
  assign ram_wdata = cmd.mark ? base_r : '0;

  // Restoring division of the cofactor by a table entry, one bit a cycle.
  assign rem_sh  = {rem_r, q_r[VAL_W-1]};
  assign divisor = {1'b0, f_r[ENT_W-1:0]};
  assign sub_ok  = (rem_sh >= divisor);
  assign rem_sub = rem_sh - divisor;

  always_comb begin
    sts.clr_last  = (pos_r == POS_W'(TABLE_SIZE - 1));
    sts.row_last  = (pos_adv >= POS_W'(TABLE_SIZE));
    sts.base_last = (base_r == ENT_W'(2));
    sts.val_ok    = ({1'b0, in_value} < (VAL_W + 1)'(TABLE_SIZE));
    sts.val_small = (in_value[VAL_W-1:1] == '0);
    sts.is_prime  = (ram_rdata == '0);
    sts.div_last  = (dcnt_r == '1);
    sts.q_one     = (q_r == VAL_W'(1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      base_r <= SIEVE_TOP;
    end else begin
      if (cmd.clr_step) begin
        pos_r <= pos_r + POS_W'(1);
      end else if (cmd.row_init) begin
        pos_r <= POS_W'(base_sq);
      end else if (cmd.mark) begin
        pos_r <= pos_adv;
      end
      if (cmd.next_base) begin
        base_r <= base_r - ENT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n_r <= in_value;
    end else if (cmd.emit) begin
      n_r <= q_r;
    end
    if (cmd.pick) begin
      if (ram_rdata == '0) begin
        f_r <= n_r;
        q_r <= VAL_W'(1);
      end else begin
        f_r <= VAL_W'(ram_rdata);
        q_r <= n_r;
      end
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[VAL_W-2:0], sub_ok};
      rem_r  <= sub_ok ? rem_sub[ENT_W-1:0] : rem_sh[ENT_W-1:0];
      dcnt_r <= dcnt_r + DIV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_none) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_factor_r <= f_r;
      out_last_r   <= (q_r == VAL_W'(1));
      out_none_r   <= 1'b0;
    end else if (cmd.emit_none) begin
      out_factor_r <= '0;
      out_last_r   <= 1'b1;
      out_none_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_factor = out_factor_r;
  assign out_last   = out_last_r;
  assign out_none   = out_none_r;

endmodule

// ===== rtl/prime_factorizer_spf_sieve.sv =====
// Prime factorizer over a smallest-prime-factor table.
// Input channel: in_valid / in_stall carry one 16-bit word in_value, the number
// to factor. Result channel: out_valid / out_stall carry one prime factor per
// word in out_factor, in ascending order with repetition; out_last marks the
// final factor of a number, and 0 or 1 gives one word with out_none and
// out_last set and a factor of 0.
// After reset the block clears the 65,536-entry table and then sieves it with
// every base from 255 down to 2, one table write a cycle within each row.
// in_stall stays high through all of this.
// Per factor the block does one table read, a restoring division of the cofactor
// by the table entry, and hands the factor to the output register; the last,
// prime cofactor skips the division. A number has at most 15 factors.
// One number is worked on at a time.
// The output register decouples the two channels: a stalled receiver holds the
// current word and pauses the factor loop, and a new number is taken while the
// final word of the previous one is still waiting.
module prime_factorizer_spf_sieve (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [pfs_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pfs_pkg::VAL_W-1:0] out_factor,
  output logic                      out_last,
  output logic                      out_none
);

  import pfs_pkg::*;

  pfs_cmd_t cmd;
  pfs_sts_t sts;

  pfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_factor (out_factor),
    .out_last   (out_last),
    .out_none   (out_none)
  );

endmodule

// ===== rtl/pfs_check.sv =====
module pfs_check (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [pfs_pkg::VAL_W-1:0] out_factor,
  input logic                      out_last,
  input logic                      out_none
);

  import pfs_pkg::*;

  // Reset empties the output register on the following edge.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A word for a number without factors is marked last and carries a factor of zero.
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none |-> out_last && (out_factor == '0))
    else $error("no-factor word is not a lone zero word");

  // Every real factor is a prime, hence at least two.
  a_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_none |-> (out_factor > VAL_W'(1)))
    else $error("factor below two");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_factor) &&
      $stable(out_last) && $stable(out_none))
    else $error("stalled result word changed");

endmodule

bind prime_factorizer_spf_sieve pfs_check u_pfs_check (.*);

// ===== sim/pfs_checker.sv =====
module pfs_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [pfs_pkg::VAL_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [pfs_pkg::VAL_W-1:0] out_factor,
  input  logic                      out_last,
  input  logic                      out_none,
  output int                        mismatches,
  output int                        pending
);

  typedef struct packed {
    logic [pfs_pkg::VAL_W-1:0] value;
    logic [pfs_pkg::VAL_W-1:0] factor;
    logic                      last;
    logic                      none;
  } factor_word_t;

  factor_word_t factor_words[$];
  factor_word_t want;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int least_prime_factor(input int n);
    for (int d = 2; d * d <= n; d++) begin
      if (n % d == 0) return d;
    end
    return n;
  endfunction

  // Splits a number into its prime factors, smallest first, and queues one
  // word per factor. Zero and one give a single word flagged as having none.
  function automatic void queue_factors(input logic [pfs_pkg::VAL_W-1:0] v);
    int           rest;
    int           f;
    factor_word_t w;
    rest    = v;
    w.value = v;
    if (rest <= 1) begin
      w.factor = '0;
      w.last   = 1'b1;
      w.none   = 1'b1;
      factor_words.push_back(w);
      return;
    end
    while (rest > 1) begin
      f        = least_prime_factor(rest);
      rest     = rest / f;
      w.factor = f[pfs_pkg::VAL_W-1:0];
      w.last   = (rest == 1);
      w.none   = 1'b0;
      factor_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (factor_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got factor %0d last %0b none %0b",
                   $time, out_factor, out_last, out_none);
          mismatches++;
        end else begin
          want = factor_words.pop_front();
          if (out_factor !== want.factor) begin
            $display("%0t: value %0d factor: expected %0d, got %0d",
                     $time, want.value, want.factor, out_factor);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: value %0d last: expected %0b, got %0b",
                     $time, want.value, want.last, out_last);
            mismatches++;
          end
          if (out_none !== want.none) begin
            $display("%0t: value %0d none: expected %0b, got %0b",
                     $time, want.value, want.none, out_none);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_factors(in_value);
      end
      pending = factor_words.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [pfs_pkg::VAL_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [pfs_pkg::VAL_W-1:0] out_factor;
  logic                      out_last;
  logic                      out_none;
  int                        mismatches;
  int                        pending;
  logic                      fast_tx;
  logic                      fast_rx;

  prime_factorizer_spf_sieve i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_factor(out_factor),
    .out_last  (out_last),
    .out_none  (out_none)
  );

  pfs_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_factor(out_factor),
    .out_last  (out_last),
    .out_none  (out_none),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timeout that ends the run as failed if the test has not finished.
  initial begin
    #(12 * 2000000);
    $display("prime_factorizer_spf_sieve test failed");
    $finish;
  end

  // Receiver: stalls at random before taking each word, or not at all in the fast phases.
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      hold = fast_rx ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_value(input logic [pfs_pkg::VAL_W-1:0] v);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // The sender goes idle so that the last word is not taken again.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [pfs_pkg::VAL_W-1:0] random_value();
    int v;
    int p;
    v = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4:          v = $urandom_range(0, 3);
      5, 6, 7: begin
        // Products of small primes give long runs of factors.
        repeat ($urandom_range(1, 15)) begin
          case ($urandom_range(0, 5))
            0:       p = 2;
            1:       p = 3;
            2:       p = 5;
            3:       p = 7;
            4:       p = 11;
            default: p = 13;
          endcase
          if (v * p < 65536) v = v * p;
        end
      end
      8: begin
        p = $urandom_range(2, 255);
        v = p * $urandom_range(1, 65535 / p);
      end
      default: v = $urandom_range(0, 1023);
    endcase
    return v[pfs_pkg::VAL_W-1:0];
  endfunction

  initial begin
    logic [pfs_pkg::VAL_W-1:0] directed [$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    fast_tx  = 1'b0;
    fast_rx  = 1'b0;
    // Zero and one, the smallest primes, the largest prime, all-ones, the
    // longest chain of factors, squares of the top table entries, and a prime
    // above 255 left over after dividing out a table entry.
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd65535, 16'd65534,
                 16'd65521, 16'd32768, 16'd65025, 16'd63001, 16'd64507,
                 16'd256, 16'd49152, 16'd59049, 16'd46656, 16'd30030,
                 16'd43690, 16'd21845, 16'd257, 16'd65533};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_value(directed[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      fast_tx = ph[0];
      fast_rx = ph[1];
      for (int k = 0; k < 38; k++) begin
        send_value(random_value());
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("prime_factorizer_spf_sieve test passed");
    end else begin
      $display("prime_factorizer_spf_sieve test failed");
    end
    $finish;
  end

endmodule

// ===== prime_factorizer_spf_sieve.f =====
rtl/pfs_pkg.sv
rtl/pfs_ram.sv
rtl/pfs_ctrl.sv
rtl/pfs_dpath.sv
rtl/prime_factorizer_spf_sieve.sv
rtl/pfs_check.sv
sim/pfs_checker.sv
sim/tb.sv
